>>> hdl/rx_descriptor_ring_drain_macros.svh
// Assertion helpers for the receive ring drain engine.
`ifndef RX_DESCRIPTOR_RING_DRAIN_MACROS_SVH
`define RX_DESCRIPTOR_RING_DRAIN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rdr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rdr check failed");

`endif

>>> hdl/rdr_pkg.sv
package rdr_pkg;

  localparam int INDEX_BITS_DEF   = 16;
  localparam int LENGTH_BITS_DEF  = 12;
  localparam int COUNTER_BITS_DEF = 32;

  localparam int IDX_FIELD_W = 16;
  localparam int LEN_FIELD_W = 12;
  localparam int HDR_W       = 4;
  localparam int CNT_OUT_W   = 32;
  localparam int NUM_CNT     = 7;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BUFFER_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_OFFSET     = 1'b1;

  localparam logic [LEN_FIELD_W-1:0] MAX_LEN_RESET    = 12'd2048;
  localparam logic [HDR_W-1:0]       HDR_OFFSET_RESET = 4'd2;

  localparam logic [IDX_FIELD_W-1:0] DISCARD_CLEAR_MARK = 16'hC000;

  localparam logic [2:0] CNT_OVERRUN  = 3'd0;
  localparam logic [2:0] CNT_CRC      = 3'd1;
  localparam logic [2:0] CNT_OVERFLOW = 3'd2;
  localparam logic [2:0] CNT_FRAME    = 3'd3;
  localparam logic [2:0] CNT_LENGTH   = 3'd4;
  localparam logic [2:0] CNT_FRAGMENT = 3'd5;
  localparam logic [2:0] CNT_OTHER    = 3'd6;

  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_DESC = 1'b1;

  typedef enum logic [2:0] {
    V_DELIVER      = 3'd0,
    V_OVERSIZE     = 3'd1,
    V_FRAGMENT     = 3'd2,
    V_FLAGGED      = 3'd3,
    V_POLL_GRANTED = 3'd4,
    V_RING_EMPTY   = 3'd5,
    V_IGNORED      = 3'd6
  } verdict_e;

endpackage

>>> hdl/rx_descriptor_ring_drain.sv
// Receive ring drain engine.
// Result path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while out_stall_i is low; the state update logic sits between the two registers.
// Reset (rst_ni low, async): consumer index, discard tracking, grants and counters
// clear to zero; max_buffer_length returns to 2048 and header_offset to 2.
`include "rx_descriptor_ring_drain_macros.svh"

module rx_descriptor_ring_drain #(
  parameter int INDEX_BITS   = rdr_pkg::INDEX_BITS_DEF,
  parameter int LENGTH_BITS  = rdr_pkg::LENGTH_BITS_DEF,
  parameter int COUNTER_BITS = rdr_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [rdr_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [rdr_pkg::CFG_DATA_W-1:0]    cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [rdr_pkg::IDX_FIELD_W-1:0]   producer_index_i,
  input  logic [rdr_pkg::IDX_FIELD_W-1:0]   discard_count_i,
  input  logic [rdr_pkg::IDX_FIELD_W-1:0]   budget_i,
  input  logic [rdr_pkg::LEN_FIELD_W-1:0]   frame_length_i,
  input  logic                              start_of_packet_i,
  input  logic                              end_of_packet_i,
  input  logic                              crc_error_i,
  input  logic                              overflow_error_i,
  input  logic                              frame_error_i,
  input  logic                              long_error_i,
  input  logic                              receive_error_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rdr_pkg::verdict_e                 verdict_o,
  output logic [rdr_pkg::LEN_FIELD_W-1:0]   payload_length_o,
  output logic [rdr_pkg::IDX_FIELD_W-1:0]   granted_o,
  output logic                              clear_discards_o,
  output logic [rdr_pkg::IDX_FIELD_W-1:0]   consumer_index_o,
  output logic [rdr_pkg::CNT_OUT_W-1:0]     overrun_count_o,
  output logic [rdr_pkg::CNT_OUT_W-1:0]     crc_count_o,
  output logic [rdr_pkg::CNT_OUT_W-1:0]     overflow_count_o,
  output logic [rdr_pkg::CNT_OUT_W-1:0]     frame_error_count_o,
  output logic [rdr_pkg::CNT_OUT_W-1:0]     length_error_count_o,
  output logic [rdr_pkg::CNT_OUT_W-1:0]     fragment_count_o,
  output logic [rdr_pkg::CNT_OUT_W-1:0]     other_error_count_o
);

  import rdr_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W;

  // configuration
  logic [LEN_FIELD_W-1:0] max_len_q;
  logic [HDR_W-1:0]       hdr_off_q;

  // input register
  logic                   in_valid_q, in_valid_d;
  logic                   kind_q;
  logic [IDX_FIELD_W-1:0] prod_q, disc_q, budget_q;
  logic [LEN_FIELD_W-1:0] len_q;
  logic                   sop_q, eop_q, crc_q, ovf_q, frm_q, lng_q, rxe_q;

  // engine state
  logic [INDEX_BITS-1:0]   cons_q, cons_d;
  logic [IDX_FIELD_W-1:0]  seen_q, seen_d;
  logic [IDX_FIELD_W-1:0]  grant_q, grant_d;
  logic [COUNTER_BITS-1:0] cnt_q [NUM_CNT];
  logic [COUNTER_BITS-1:0] cnt_d [NUM_CNT];

  // result register
  logic                   out_valid_q, out_valid_d;
  verdict_e               verdict_q, verdict_d;
  logic [LEN_FIELD_W-1:0] payload_q, payload_d;
  logic [IDX_FIELD_W-1:0] granted_q, granted_d;
  logic                   clear_q, clear_d;

  logic                   advance, in_take;
  logic [INDEX_BITS-1:0]  prod_idx, pending;
  logic [IDX_FIELD_W-1:0] pending_w;
  logic [LENGTH_BITS-1:0] len_c, hdr_c;
  logic                   oversize, fragment, any_flag;
  logic [NUM_CNT-1:0]     hit;
  logic [IDX_FIELD_W-1:0] overrun_add;

  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign in_valid_d  = in_take | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      hdr_off_q <= HDR_OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_BUFFER_LENGTH: max_len_q <= cfg_data_i[LEN_FIELD_W-1:0];
        REG_HEADER_OFFSET:     hdr_off_q <= cfg_data_i[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q   <= kind_i;
      prod_q   <= producer_index_i;
      disc_q   <= discard_count_i;
      budget_q <= budget_i;
      len_q    <= frame_length_i;
      sop_q    <= start_of_packet_i;
      eop_q    <= end_of_packet_i;
      crc_q    <= crc_error_i;
      ovf_q    <= overflow_error_i;
      frm_q    <= frame_error_i;
      lng_q    <= long_error_i;
      rxe_q    <= receive_error_i;
    end
  end

  assign prod_idx  = prod_q[INDEX_BITS-1:0];
  assign pending   = prod_idx - cons_q;
  assign pending_w = IDX_FIELD_W'(pending);
  assign len_c     = LENGTH_BITS'(len_q);
  assign hdr_c     = LENGTH_BITS'(hdr_off_q);
  assign oversize  = CMP_W'(len_c) > CMP_W'(max_len_q);
  assign fragment  = ~sop_q | ~eop_q;
  assign any_flag  = crc_q | ovf_q | frm_q | lng_q | rxe_q;

  always_comb begin
    cons_d      = cons_q;
    seen_d      = seen_q;
    grant_d     = grant_q;
    verdict_d   = V_IGNORED;
    payload_d   = '0;
    granted_d   = '0;
    clear_d     = 1'b0;
    hit         = '0;
    overrun_add = '0;

    if (kind_q == KIND_POLL) begin
      if (prod_idx == cons_q) begin
        verdict_d = V_RING_EMPTY;
      end else begin
        if (disc_q > seen_q) begin
          overrun_add = disc_q - seen_q;
          if (disc_q >= DISCARD_CLEAR_MARK) begin
            seen_d  = '0;
            clear_d = 1'b1;
          end else begin
            seen_d = disc_q;
          end
        end
        granted_d = (pending_w < budget_q) ? pending_w : budget_q;
        grant_d   = granted_d;
        verdict_d = V_POLL_GRANTED;
      end
    end else if (grant_q != '0) begin
      grant_d = grant_q - 1'b1;
      cons_d  = cons_q + 1'b1;
      if (oversize) begin
        hit[CNT_LENGTH] = 1'b1;
        verdict_d       = V_OVERSIZE;
      end else if (fragment) begin
        hit[CNT_FRAGMENT] = 1'b1;
        verdict_d         = V_FRAGMENT;
      end else if (any_flag) begin
        hit[CNT_CRC]      = crc_q;
        hit[CNT_OVERFLOW] = ovf_q;
        hit[CNT_FRAME]    = frm_q;
        hit[CNT_LENGTH]   = lng_q;
        hit[CNT_OTHER]    = rxe_q & ~crc_q & ~ovf_q & ~frm_q & ~lng_q;
        verdict_d         = V_FLAGGED;
      end else begin
        payload_d = (len_c >= hdr_c) ? LEN_FIELD_W'(len_c - hdr_c) : '0;
        verdict_d = V_DELIVER;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      if (3'(i) == CNT_OVERRUN) begin
        cnt_d[i] = cnt_q[i] + COUNTER_BITS'(overrun_add);
      end else begin
        cnt_d[i] = cnt_q[i] + COUNTER_BITS'(hit[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cons_q  <= '0;
      seen_q  <= '0;
      grant_q <= '0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (advance) begin
      cons_q  <= cons_d;
      seen_q  <= seen_d;
      grant_q <= grant_d;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      verdict_q <= verdict_d;
      payload_q <= payload_d;
      granted_q <= granted_d;
      clear_q   <= clear_d;
    end
  end

  // state only moves when the result register loads, so it matches the held item
  assign out_valid_o          = out_valid_q;
  assign verdict_o            = verdict_q;
  assign payload_length_o     = payload_q;
  assign granted_o            = granted_q;
  assign clear_discards_o     = clear_q;
  assign consumer_index_o     = IDX_FIELD_W'(cons_q);
  assign overrun_count_o      = CNT_OUT_W'(cnt_q[CNT_OVERRUN]);
  assign crc_count_o          = CNT_OUT_W'(cnt_q[CNT_CRC]);
  assign overflow_count_o     = CNT_OUT_W'(cnt_q[CNT_OVERFLOW]);
  assign frame_error_count_o  = CNT_OUT_W'(cnt_q[CNT_FRAME]);
  assign length_error_count_o = CNT_OUT_W'(cnt_q[CNT_LENGTH]);
  assign fragment_count_o     = CNT_OUT_W'(cnt_q[CNT_FRAGMENT]);
  assign other_error_count_o  = CNT_OUT_W'(cnt_q[CNT_OTHER]);

  `RDR_ASSERT_IMPL(a_clear_only_on_grant, out_valid_q && clear_q, verdict_q == V_POLL_GRANTED)
  `RDR_ASSERT_IMPL(a_payload_only_deliver, out_valid_q && verdict_q != V_DELIVER, payload_q == '0)
  `RDR_ASSERT_IMPL(a_seen_below_mark, 1'b1, seen_q < DISCARD_CLEAR_MARK)
  `RDR_ASSERT_NEXT(a_ungranted_no_move, advance && kind_q == KIND_DESC && grant_q == '0, $stable(cons_q) && $stable(grant_q))

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import rdr_pkg::*;

  localparam logic [4:0] FL_NONE = 5'b00000;
  localparam logic [4:0] FL_RXE  = 5'b00001;
  localparam logic [4:0] FL_LNG  = 5'b00010;
  localparam logic [4:0] FL_ALL  = 5'b11111;
  localparam int         ITEMS_PER_PHASE = 60;
  localparam int         HOLD_CYCLES     = 300;

  typedef struct packed {
    logic                   kind;
    logic [IDX_FIELD_W-1:0] prod;
    logic [IDX_FIELD_W-1:0] disc;
    logic [IDX_FIELD_W-1:0] budget;
    logic [LEN_FIELD_W-1:0] len;
    logic                   sop;
    logic                   eop;
    logic [4:0]             flags;  // crc, overflow, frame, long, receive
  } ring_item_t;

  typedef struct packed {
    verdict_e                        verdict;
    logic [LEN_FIELD_W-1:0]          payload;
    logic [IDX_FIELD_W-1:0]          granted;
    logic                            clear;
    logic [IDX_FIELD_W-1:0]          cons;
    logic [NUM_CNT-1:0][CNT_OUT_W-1:0] cnt;
  } ring_result_t;

  typedef struct {
    ring_item_t   item;
    bit           typed;
    ring_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic         in_valid = 1'b0;
  logic         in_stall;
  ring_item_t   cur = '0;
  bit           cur_typed = 1'b0;
  ring_result_t cur_want = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  verdict_e               out_verdict;
  logic [LEN_FIELD_W-1:0] out_payload;
  logic [IDX_FIELD_W-1:0] out_granted;
  logic                   out_clear;
  logic [IDX_FIELD_W-1:0] out_cons;
  logic [CNT_OUT_W-1:0]   out_overrun, out_crc, out_overflow, out_frame;
  logic [CNT_OUT_W-1:0]   out_length, out_fragment, out_other;

  // ring state as seen by the checker
  logic [IDX_FIELD_W-1:0]            ring_cons;
  logic [IDX_FIELD_W-1:0]            tracked_discards;
  logic [IDX_FIELD_W-1:0]            grants_left;
  logic [NUM_CNT-1:0][CNT_OUT_W-1:0] stat_cnt;
  logic [LEN_FIELD_W-1:0]            max_len_reg;
  logic [HDR_W-1:0]                  hdr_off_reg;

  // ring state as tracked by the stimulus side
  logic [IDX_FIELD_W-1:0] gen_cons = '0;
  logic [IDX_FIELD_W-1:0] gen_seen = '0;
  logic [IDX_FIELD_W-1:0] gen_grant = '0;

  ring_result_t pending_results[$];
  int  bad_fields = 0;
  int  items_done = 0;
  bit  quiet = 1'b0;
  int  hold_reqs = 0;
  int  hold_served = 0;
  int  hold_left = 0;

  string cnt_name [NUM_CNT] = '{"overrun_count", "crc_count", "overflow_count",
                                "frame_error_count", "length_error_count",
                                "fragment_count", "other_error_count"};

  rx_descriptor_ring_drain i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (cur.kind),
    .producer_index_i    (cur.prod),
    .discard_count_i     (cur.disc),
    .budget_i            (cur.budget),
    .frame_length_i      (cur.len),
    .start_of_packet_i   (cur.sop),
    .end_of_packet_i     (cur.eop),
    .crc_error_i         (cur.flags[4]),
    .overflow_error_i    (cur.flags[3]),
    .frame_error_i       (cur.flags[2]),
    .long_error_i        (cur.flags[1]),
    .receive_error_i     (cur.flags[0]),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .verdict_o           (out_verdict),
    .payload_length_o    (out_payload),
    .granted_o           (out_granted),
    .clear_discards_o    (out_clear),
    .consumer_index_o    (out_cons),
    .overrun_count_o     (out_overrun),
    .crc_count_o         (out_crc),
    .overflow_count_o    (out_overflow),
    .frame_error_count_o (out_frame),
    .length_error_count_o(out_length),
    .fragment_count_o    (out_fragment),
    .other_error_count_o (out_other)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic ring_item_t mk_poll(input logic [15:0] prod, input logic [15:0] disc,
                                         input logic [15:0] budget);
    ring_item_t r;
    r = '0;
    r.kind = KIND_POLL;
    r.prod = prod;
    r.disc = disc;
    r.budget = budget;
    return r;
  endfunction

  function automatic ring_item_t mk_desc(input logic [11:0] len, input logic sop,
                                         input logic eop, input logic [4:0] flags);
    ring_item_t r;
    r = '0;
    r.kind = KIND_DESC;
    r.len = len;
    r.sop = sop;
    r.eop = eop;
    r.flags = flags;
    return r;
  endfunction

  function automatic ring_result_t want_of(input verdict_e v, input logic [11:0] payload,
                                           input logic [15:0] granted, input logic clear,
                                           input logic [15:0] cons);
    ring_result_t w;
    w = '0;
    w.verdict = v;
    w.payload = payload;
    w.granted = granted;
    w.clear = clear;
    w.cons = cons;
    return w;
  endfunction

  function automatic ring_result_t drain_step(input ring_item_t r);
    ring_result_t res;
    logic [IDX_FIELD_W-1:0] pend;
    res = '0;
    if (r.kind == KIND_POLL) begin
      if (r.prod == ring_cons) begin
        res.verdict = V_RING_EMPTY;
      end else begin
        if (r.disc > tracked_discards) begin
          stat_cnt[CNT_OVERRUN] += CNT_OUT_W'(r.disc - tracked_discards);
          tracked_discards = r.disc;
          if (tracked_discards >= DISCARD_CLEAR_MARK) begin
            tracked_discards = '0;
            res.clear = 1'b1;
          end
        end
        pend = r.prod - ring_cons;
        res.granted = (pend < r.budget) ? pend : r.budget;
        grants_left = res.granted;
        res.verdict = V_POLL_GRANTED;
      end
    end else if (grants_left == '0) begin
      res.verdict = V_IGNORED;
    end else begin
      grants_left--;
      ring_cons++;
      if (r.len > max_len_reg) begin
        stat_cnt[CNT_LENGTH]++;
        res.verdict = V_OVERSIZE;
      end else if (!r.sop || !r.eop) begin
        stat_cnt[CNT_FRAGMENT]++;
        res.verdict = V_FRAGMENT;
      end else if (|r.flags) begin
        if (r.flags[4]) stat_cnt[CNT_CRC]++;
        if (r.flags[3]) stat_cnt[CNT_OVERFLOW]++;
        if (r.flags[2]) stat_cnt[CNT_FRAME]++;
        if (r.flags[1]) stat_cnt[CNT_LENGTH]++;
        if (r.flags == FL_RXE) stat_cnt[CNT_OTHER]++;
        res.verdict = V_FLAGGED;
      end else begin
        res.payload = (r.len >= LEN_FIELD_W'(hdr_off_reg)) ? r.len - LEN_FIELD_W'(hdr_off_reg)
                                                           : '0;
        res.verdict = V_DELIVER;
      end
    end
    res.cons = ring_cons;
    res.cnt = stat_cnt;
    return res;
  endfunction

  function automatic ring_item_t rand_desc();
    ring_item_t r;
    int sel;
    r.kind = KIND_DESC;
    r.prod = 16'($urandom);
    r.disc = 16'($urandom);
    r.budget = 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 40) r.len = 12'($urandom);
    else if (sel < 70) r.len = max_len_reg + 12'($urandom_range(0, 4)) - 12'd2;
    else r.len = 12'($urandom_range(0, 20));
    sel = $urandom_range(99);
    if (sel < 60) begin
      r.sop = 1'b1;
      r.eop = 1'b1;
      r.flags = FL_NONE;
    end else if (sel < 70) begin
      r.sop = 1'b1;
      r.eop = 1'b1;
      r.flags = FL_RXE;
    end else begin
      {r.sop, r.eop, r.flags} = 7'($urandom);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      bad_fields++;
      if (bad_fields <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // model update on every accepted item
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      ring_result_t p;
      p = drain_step(cur);
      if (cur_typed) begin
        p.verdict = cur_want.verdict;
        p.payload = cur_want.payload;
        p.granted = cur_want.granted;
        p.clear = cur_want.clear;
        p.cons = cur_want.cons;
      end
      pending_results.push_back(p);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ring_result_t got, want;
      got.verdict = out_verdict;
      got.payload = out_payload;
      got.granted = out_granted;
      got.clear = out_clear;
      got.cons = out_cons;
      got.cnt[CNT_OVERRUN] = out_overrun;
      got.cnt[CNT_CRC] = out_crc;
      got.cnt[CNT_OVERFLOW] = out_overflow;
      got.cnt[CNT_FRAME] = out_frame;
      got.cnt[CNT_LENGTH] = out_length;
      got.cnt[CNT_FRAGMENT] = out_fragment;
      got.cnt[CNT_OTHER] = out_other;
      if (pending_results.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10)
          $display("unexpected item out: verdict %0d", got.verdict);
      end else begin
        want = pending_results.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(got.verdict));
        check_field("payload_length", 32'(want.payload), 32'(got.payload));
        check_field("granted", 32'(want.granted), 32'(got.granted));
        check_field("clear_discards", 32'(want.clear), 32'(got.clear));
        check_field("consumer_index", 32'(want.cons), 32'(got.cons));
        for (int i = 0; i < NUM_CNT; i++)
          check_field(cnt_name[i], want.cnt[i], got.cnt[i]);
      end
    end
  end

  // sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 30);
    end
  end

  task automatic offer(input ring_item_t r, input bit typed, input ring_result_t want);
    if (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cur <= r;
    cur_typed <= typed;
    cur_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] max_len,
                            input logic [CFG_DATA_W-1:0] hdr_data);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_BUFFER_LENGTH;
    cfg_data <= max_len;
    @(posedge clk);
    cfg_index <= REG_HEADER_OFFSET;
    cfg_data <= hdr_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len_reg = max_len;
    hdr_off_reg = hdr_data[HDR_W-1:0];
  endtask

  task automatic poll_item(input logic [15:0] prod, input logic [15:0] disc,
                           input logic [15:0] budget);
    logic [15:0] pend;
    offer(mk_poll(prod, disc, budget), 1'b0, '0);
    items_done++;
    if (prod != gen_cons) begin
      if (disc > gen_seen) gen_seen = (disc >= DISCARD_CLEAR_MARK) ? '0 : disc;
      pend = prod - gen_cons;
      gen_grant = (pend < budget) ? pend : budget;
    end
  endtask

  task automatic desc_item(input ring_item_t r);
    offer(r, 1'b0, '0);
    if (gen_grant != '0) begin
      gen_grant--;
      gen_cons++;
      items_done++;
    end
  endtask

  task automatic run_phase();
    int sel, ndesc;
    logic [15:0] prod, disc, budget;
    items_done = 0;
    while (items_done < ITEMS_PER_PHASE) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1)) poll_item(16'($urandom), 16'($urandom), 16'($urandom));
        else desc_item(rand_desc());
      end else begin
        sel = $urandom_range(99);
        if (sel < 5) prod = gen_cons;
        else if (sel < 12) prod = 16'($urandom);
        else prod = gen_cons + 16'($urandom_range(1, 12));
        budget = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 12)) : 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 50) disc = gen_seen;
        else if (sel < 90) disc = gen_seen + 16'($urandom_range(1, 16'h2000));
        else disc = 16'($urandom);
        poll_item(prod, disc, budget);
        if ($urandom_range(99) < 80) ndesc = gen_grant + $urandom_range(0, 1);
        else ndesc = $urandom_range(0, gen_grant);
        if (ndesc > 16) ndesc = 16;
        repeat (ndesc) desc_item(rand_desc());
      end
    end
  endtask

  initial begin
    dir_row_t dir_tbl [20];
    ring_cons = '0;
    tracked_discards = '0;
    grants_left = '0;
    stat_cnt = '0;
    max_len_reg = MAX_LEN_RESET;
    hdr_off_reg = HDR_OFFSET_RESET;

    dir_tbl = '{
      '{mk_desc(12'd100, 1, 1, FL_NONE), 1'b1, want_of(V_IGNORED, 0, 0, 0, 0)},
      '{mk_poll(16'd0, 16'h7777, 16'd9), 1'b1, want_of(V_RING_EMPTY, 0, 0, 0, 0)},
      '{mk_poll(16'd5, 16'd3, 16'hFFFF), 1'b1, want_of(V_POLL_GRANTED, 0, 5, 0, 0)},
      '{mk_desc(12'd100, 1, 1, FL_NONE), 1'b1, want_of(V_DELIVER, 98, 0, 0, 1)},
      '{mk_desc(12'd2049, 0, 0, FL_ALL), 1'b1, want_of(V_OVERSIZE, 0, 0, 0, 2)},
      '{mk_desc(12'd2048, 1, 0, FL_NONE), 1'b1, want_of(V_FRAGMENT, 0, 0, 0, 3)},
      '{mk_desc(12'd1, 1, 1, FL_ALL), 1'b1, want_of(V_FLAGGED, 0, 0, 0, 4)},
      '{mk_desc(12'd1, 1, 1, FL_RXE), 1'b1, want_of(V_FLAGGED, 0, 0, 0, 5)},
      '{mk_desc(12'd7, 1, 1, FL_NONE), 1'b1, want_of(V_IGNORED, 0, 0, 0, 5)},
      '{mk_poll(16'd5, 16'hFFFF, 16'd3), 1'b1, want_of(V_RING_EMPTY, 0, 0, 0, 5)},
      '{mk_poll(16'hFFFF, 16'hC000, 16'd2), 1'b1, want_of(V_POLL_GRANTED, 0, 2, 1, 5)},
      '{mk_desc(12'd0, 1, 1, FL_NONE), 1'b1, want_of(V_DELIVER, 0, 0, 0, 6)},
      '{mk_poll(16'd4, 16'd0, 16'd1), 1'b1, want_of(V_POLL_GRANTED, 0, 1, 0, 6)},
      '{mk_desc(12'hFFF, 1, 1, FL_NONE), 1'b1, want_of(V_OVERSIZE, 0, 0, 0, 7)},
      '{mk_poll(16'h1234, 16'hFFFF, 16'd0), 1'b1, want_of(V_POLL_GRANTED, 0, 0, 1, 7)},
      '{mk_desc(12'd2, 1, 1, FL_NONE), 1'b1, want_of(V_IGNORED, 0, 0, 0, 7)},
      '{mk_poll(16'd8, 16'd1, 16'hFFFF), 1'b1, want_of(V_POLL_GRANTED, 0, 1, 0, 7)},
      '{mk_desc(12'd2, 1, 1, FL_LNG), 1'b1, want_of(V_FLAGGED, 0, 0, 0, 8)},
      '{mk_poll(16'd9, 16'd1, 16'd4), 1'b1, want_of(V_POLL_GRANTED, 0, 1, 0, 8)},
      '{mk_desc(12'd2048, 1, 1, FL_NONE), 1'b1, want_of(V_DELIVER, 2046, 0, 0, 9)}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) offer(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);
    gen_cons = 16'd9;
    gen_seen = 16'd1;
    gen_grant = '0;

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: set_config(12'd0, {8'($urandom), 4'hF});
        1: set_config(12'hFFF, {8'($urandom), 4'h0});
        5: set_config(MAX_LEN_RESET, {8'($urandom), HDR_OFFSET_RESET});
        default: set_config(12'($urandom), 12'($urandom));
      endcase
      quiet = (ph == 2);
      if (ph == 3) hold_reqs++;
      run_phase();
    end
    quiet = 1'b0;
    settle();

    if (bad_fields == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
